/* rtl/core/mep_pkg.sv */
`timescale 1ns / 1ps
// Package for the escape-time pixel engine: payload and configuration types,
// register indexes, fixed-point helpers and the color palette. No dependencies.
package mep_pkg;

   // Default parameter values for the top level
   localparam int unsigned PALETTE_ENTRIES_DEF = 17;
   localparam int unsigned COORD_LIMIT_DEF     = 16384;
   localparam int unsigned FRACTION_BITS_DEF   = 28;

   // Fixed field widths
   localparam int unsigned COORD_W   = 14;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned STEP_W    = 31;
   localparam int unsigned WIDTH_W   = 15;
   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned ADDR_W    = 28;
   localparam int unsigned COLOR_W   = 8;
   localparam int unsigned PAL_IDX_W = 5;
   localparam int unsigned CSR_IDX_W = 3;

   // Depth of the job queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RE_ORIGIN       = 3'd0,
      CSR_IM_ORIGIN       = 3'd1,
      CSR_RE_PITCH        = 3'd2,
      CSR_IM_PITCH        = 3'd3,
      CSR_IMAGE_WIDTH     = 3'd4,
      CSR_ITERATION_LIMIT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  pixel_address;
      logic [COUNT_W-1:0] iteration_count;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] re_origin;
      logic signed [WORD_W-1:0] im_origin;
      logic [STEP_W-1:0]        re_pitch;
      logic [STEP_W-1:0]        im_pitch;
      logic [WIDTH_W-1:0]       image_width;
      logic [COUNT_W-1:0]       iteration_limit;
   } cfg_type;

   // One pixel job handed from front to back
   typedef struct packed {
      logic signed [WORD_W-1:0] cr;
      logic signed [WORD_W-1:0] ci;
      logic [ADDR_W-1:0]        addr;
   } job_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   // Clamp a wide signed value to the signed 32-bit word range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [64:0] v);
      logic signed [64:0] hi;
      logic signed [64:0] lo;
      logic signed [WORD_W-1:0] r;
      hi = 65'sd2147483647;
      lo = -65'sd2147483648;
      if (v > hi) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

   // Palette: entries past the seventeenth are black
   function automatic rgb_type palette_rgb(input logic [PAL_IDX_W-1:0] idx);
      rgb_type c;
      case (idx)
         5'd0:    c = '{8'd66,  8'd30,  8'd15};
         5'd1:    c = '{8'd25,  8'd7,   8'd26};
         5'd2:    c = '{8'd9,   8'd1,   8'd47};
         5'd3:    c = '{8'd4,   8'd4,   8'd73};
         5'd4:    c = '{8'd0,   8'd7,   8'd100};
         5'd5:    c = '{8'd12,  8'd44,  8'd138};
         5'd6:    c = '{8'd24,  8'd82,  8'd177};
         5'd7:    c = '{8'd57,  8'd125, 8'd209};
         5'd8:    c = '{8'd134, 8'd181, 8'd229};
         5'd9:    c = '{8'd211, 8'd236, 8'd248};
         5'd10:   c = '{8'd241, 8'd233, 8'd191};
         5'd11:   c = '{8'd248, 8'd201, 8'd95};
         5'd12:   c = '{8'd255, 8'd170, 8'd0};
         5'd13:   c = '{8'd204, 8'd128, 8'd0};
         5'd14:   c = '{8'd153, 8'd87,  8'd0};
         5'd15:   c = '{8'd106, 8'd52,  8'd3};
         5'd16:   c = '{8'd16,  8'd16,  8'd16};
         default: c = '{8'd0,   8'd0,   8'd0};
      endcase
      return c;
   endfunction

endpackage

/* rtl/core/mep_front.sv */
`timescale 1ns / 1ps
// Front end: accepts pixel items, forms the point c and the pixel address,
// and pushes one job per item into the queue. Uses mep_pkg.
module mep_front import mep_pkg::*; #(
   parameter int unsigned COORD_LIMIT = COORD_LIMIT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    q_full,
   output logic    q_push,
   output job_type q_job
);

   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'(COORD_LIMIT - 1);
   localparam int unsigned PROD_W = COORD_W + STEP_W;
   localparam int unsigned AMUL_W = COORD_W + WIDTH_W;

   logic                 s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]    prod_r_ff, prod_r_in;
   logic [PROD_W-1:0]    prod_i_ff, prod_i_in;
   logic [AMUL_W-1:0]    prod_a_ff, prod_a_in;
   logic [COORD_W-1:0]   x_ff, x_in;
   logic [COORD_W-1:0]   x_m, y_m;
   logic                 accept;
   logic signed [64:0]   sum_r, sum_i;
   logic [AMUL_W-1:0]    addr_full;

   // Stall only when the product stage is full and cannot drain
   assign req_stall = s1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = s1_valid_ff && !q_full;

   // Mask coordinates and multiply by the steps and the row width
   always_comb begin
      x_m         = req_payload.x & COORD_MASK;
      y_m         = req_payload.y & COORD_MASK;
      prod_r_in   = accept ? PROD_W'(x_m) * PROD_W'(cfg.re_pitch) : prod_r_ff;
      prod_i_in   = accept ? PROD_W'(y_m) * PROD_W'(cfg.im_pitch) : prod_i_ff;
      prod_a_in   = accept ? AMUL_W'(y_m) * AMUL_W'(cfg.image_width) : prod_a_ff;
      x_in        = accept ? x_m : x_ff;
      s1_valid_in = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_ff);
   end

   // Add the frame origin, clamp, and form the address
   always_comb begin
      sum_r     = {20'd0, prod_r_ff} + {{33{cfg.re_origin[WORD_W-1]}}, cfg.re_origin};
      sum_i     = {20'd0, prod_i_ff} + {{33{cfg.im_origin[WORD_W-1]}}, cfg.im_origin};
      addr_full = prod_a_ff + AMUL_W'(x_ff);
      q_job.cr   = sat_word(sum_r);
      q_job.ci   = sat_word(sum_i);
      q_job.addr = addr_full[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_r_ff <= prod_r_in;
      prod_i_ff <= prod_i_in;
      prod_a_ff <= prod_a_in;
      x_ff      <= x_in;
   end

endmodule

/* rtl/core/mep_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the iteration engine.
// Uses mep_pkg for the job type and depth.
module mep_queue import mep_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slots_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the slot at the tail
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff < CNT_W'(QUEUE_DEPTH)))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue underflow");
`endif

endmodule

/* rtl/core/mep_back.sv */
`timescale 1ns / 1ps
// Iteration engine: runs z = z*z + c on three 32x32 multipliers, tests escape,
// picks the palette color and holds the result register. Uses mep_pkg.
module mep_back import mep_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
   parameter int unsigned FRACTION_BITS   = FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] limit,
   input  logic               q_empty,
   input  job_type            q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload
);

   localparam int unsigned IDX_W      = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int unsigned ESC_SHIFT  = 2 * FRACTION_BITS + 2;
   localparam bit          ESC_ON     = (ESC_SHIFT < 64);
   localparam logic [63:0] ESC_THRESH = ESC_ON ? (64'd1 << ESC_SHIFT) : 64'd0;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_ADD  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic signed [WORD_W-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [WORD_W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [COUNT_W-1:0]       k_ff, k_in;
   logic [IDX_W-1:0]         mod_ff, mod_in;
   logic signed [63:0]       rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]         pidx_ff, pidx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic [63:0]              mag;
   logic                     esc;
   logic signed [63:0]       re, re_sh, im_sh;
   logic signed [64:0]       sum_r, sum_i;
   logic                     out_free;
   rgb_type                  color;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Escape test and next z from the registered products
   always_comb begin
      mag   = $unsigned(rr_ff) + $unsigned(ii_ff);
      esc   = ESC_ON && (mag > ESC_THRESH) && (k_ff != '0);
      re    = rr_ff - ii_ff;
      re_sh = re >>> FRACTION_BITS;
      im_sh = ri_ff >>> (FRACTION_BITS - 1);
      sum_r = {re_sh[63], re_sh} + {{33{cr_ff[WORD_W-1]}}, cr_ff};
      sum_i = {im_sh[63], im_sh} + {{33{ci_ff[WORD_W-1]}}, ci_ff};
      color = palette_rgb(PAL_IDX_W'(pidx_ff));
   end

   // Sequence: load job, multiply, add and test, hand off result
   always_comb begin
      state_in     = state_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      addr_in      = addr_ff;
      k_in         = k_ff;
      mod_in       = mod_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      count_in     = count_ff;
      pidx_in      = pidx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cr_in    = q_head.cr;
               ci_in    = q_head.ci;
               zr_in    = q_head.cr;
               zi_in    = q_head.ci;
               addr_in  = q_head.addr;
               k_in     = '0;
               mod_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            rr_in    = zr_ff * zr_ff;
            ii_in    = zi_ff * zi_ff;
            ri_in    = zr_ff * zi_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            if (esc) begin
               count_in = k_ff - 1'b1;
               pidx_in  = (mod_ff == '0) ? LAST_IDX : mod_ff - 1'b1;
               state_in = S_DONE;
            end else if (k_ff == limit) begin
               count_in = limit;
               pidx_in  = LAST_IDX;
               state_in = S_DONE;
            end else begin
               zr_in    = sat_word(sum_r);
               zi_in    = sat_word(sum_i);
               k_in     = k_ff + 1'b1;
               mod_in   = (mod_ff == LAST_IDX) ? '0 : mod_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in.pixel_address   = addr_ff;
               rsp_in.iteration_count = count_ff;
               rsp_in.red             = color.red;
               rsp_in.green           = color.green;
               rsp_in.blue            = color.blue;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      addr_ff  <= addr_in;
      k_ff     <= k_in;
      mod_ff   <= mod_in;
      rr_ff    <= rr_in;
      ii_ff    <= ii_in;
      ri_ff    <= ri_in;
      count_ff <= count_in;
      pidx_ff  <= pidx_in;
      rsp_ff   <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD || state_ff == S_DONE) |-> (k_ff <= limit))
      else $error("iteration index past limit");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("finished result dropped while output stalled");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result issued outside hand-off");
`endif

endmodule

/* rtl/core/mandelbrot_escape_pixel.sv */
`timescale 1ns / 1ps
// Escape-time pixel engine, top level: configuration registers, front end,
// job queue and iteration engine. Uses mep_pkg, mep_front, mep_queue, mep_back.
//
// Usage:
//   req_*  : one pixel (x, y) per item, accepted when req_valid and !req_stall.
//   rsp_*  : one result per item (address, iteration count, RGB), in order,
//            taken when rsp_valid and !rsp_stall.
//   csr_*  : register writes, index 0..5 = real origin, imaginary origin,
//            real pitch, imaginary pitch, image_width, iteration_limit;
//            csr_ready is always high.
//            Write only while no item is in flight; other indexes are ignored.
// Timing: the front end takes one item per cycle while req_stall is low, holds
//   it in its product register and pushes it into the queue when the queue is
//   not full. The iteration engine takes a load step, then a multiply step and
//   an add-and-test step for each of K+1 passes, K being the final iteration
//   index (up to the limit), then a hand-off step, and takes no new item until
//   the hand-off. The dependent multiply/add loop of the engine sets the rate;
//   the queue lets the front end take the next items meanwhile.
// Reset (synchronous): registers return to their defaults, the queue and the
//   engine empty out. A stalled result holds its register; the engine then
//   waits with its next finished result, and the queue fills before req_stall.
module mandelbrot_escape_pixel import mep_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
   parameter int unsigned COORD_LIMIT     = COORD_LIMIT_DEF,
   parameter int unsigned FRACTION_BITS   = FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_empty, q_push, q_pop;
   job_type q_job, q_head;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RE_ORIGIN:       cfg_in.re_origin       = csr_data;
            CSR_IM_ORIGIN:       cfg_in.im_origin       = csr_data;
            CSR_RE_PITCH:        cfg_in.re_pitch        = csr_data[STEP_W-1:0];
            CSR_IM_PITCH:        cfg_in.im_pitch        = csr_data[STEP_W-1:0];
            CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_data[WIDTH_W-1:0];
            CSR_ITERATION_LIMIT: cfg_in.iteration_limit = csr_data[COUNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.re_origin       <= -32'sd671088640;
         cfg_ff.im_origin       <= -32'sd536870912;
         cfg_ff.re_pitch        <= 31'd1048576;
         cfg_ff.im_pitch        <= 31'd1048576;
         cfg_ff.image_width     <= 15'd1024;
         cfg_ff.iteration_limit <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mep_front #(
      .COORD_LIMIT (COORD_LIMIT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_job)
   );

   mep_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head_job (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   mep_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .limit       (cfg_ff.iteration_limit),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
